### design/line_line_intersection_assert.svh
// Assertion macros for the line intersection RTL, used by lli_fifo.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef LINE_LINE_INTERSECTION_ASSERT_SVH
`define LINE_LINE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LLI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lli assertion failed");

// Next-cycle implication, disabled in reset.
`define LLI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lli assertion failed");

`endif

### design/lli_pkg.sv
// Package for the line intersection block: widths, shared types and helpers.
// No dependencies.
`default_nettype none

package lli_pkg;

    localparam int FIELD_W     = 32;
    localparam int COORD_WIDTH = 32;
    localparam int TOL_W       = 40;

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int DEN_W   = CROSS_W + 1;
    localparam int CMP_W   = (DEN_W > TOL_W) ? DEN_W : TOL_W;
    localparam int LO_W    = (CROSS_W + 1) / 2;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int PLO_W   = LO_W + 1 + COORD_WIDTH;
    localparam int PHI_W   = HI_W + COORD_WIDTH;
    localparam int TERM_W  = CROSS_W + COORD_WIDTH;
    localparam int NUM_W   = TERM_W + 1;
    localparam int QUO_W   = COORD_WIDTH + 1;

    localparam logic [QUO_W-1:0] SAT_LIM = QUO_W'(1) << (COORD_WIDTH - 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t qx;
        coord_t qy;
    } pts_t;

    typedef struct packed {
        logic                       parallel;
        logic signed [CROSS_W-1:0]  d1;
        logic signed [CROSS_W-1:0]  d2;
        logic signed [DEN_W-1:0]    den;
        pts_t                       pts;
    } cross_item_t;

    function automatic coord_t to_coord(input logic [FIELD_W-1:0] v);
        return coord_t'(v[COORD_WIDTH-1:0]);
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input coord_t c);
        return FIELD_W'(c);
    endfunction

endpackage

`default_nettype wire

### design/lli_if.sv
// Valid/ready channel interfaces for the line intersection block.
// Depends on lli_pkg for the field width.
`default_nettype none

interface lli_in_if;
    logic                        valid;
    logic                        ready;
    logic [lli_pkg::FIELD_W-1:0] line1_start_x;
    logic [lli_pkg::FIELD_W-1:0] line1_start_y;
    logic [lli_pkg::FIELD_W-1:0] line1_end_x;
    logic [lli_pkg::FIELD_W-1:0] line1_end_y;
    logic [lli_pkg::FIELD_W-1:0] line2_start_x;
    logic [lli_pkg::FIELD_W-1:0] line2_start_y;
    logic [lli_pkg::FIELD_W-1:0] line2_end_x;
    logic [lli_pkg::FIELD_W-1:0] line2_end_y;

    modport source (output valid, line1_start_x, line1_start_y, line1_end_x, line1_end_y,
                    line2_start_x, line2_start_y, line2_end_x, line2_end_y, input ready);
    modport sink (input valid, line1_start_x, line1_start_y, line1_end_x, line1_end_y,
                  line2_start_x, line2_start_y, line2_end_x, line2_end_y, output ready);
endinterface

interface lli_out_if;
    logic                        valid;
    logic                        ready;
    logic [lli_pkg::FIELD_W-1:0] meet_x;
    logic [lli_pkg::FIELD_W-1:0] meet_y;
    logic                        lines_meet;
    logic                        range_overflow;

    modport source (output valid, meet_x, meet_y, lines_meet, range_overflow, input ready);
    modport sink (input valid, meet_x, meet_y, lines_meet, range_overflow, output ready);
endinterface

`default_nettype wire

### design/lli_front.sv
// Front end: accepts point sets, forms the two cross products and classifies
// parallel lines against the tolerance. Depends on lli_pkg and lli_in_if.
`default_nettype none

module lli_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lli_in_if.sink                         items_in,
    input  wire logic [lli_pkg::TOL_W-1:0] tol,
    output lli_pkg::cross_item_t           item,
    output logic                           item_valid,
    input  wire logic                      item_ready
);
    import lli_pkg::*;

    logic       adv;
    logic [4:0] vld_reg;

    coord_t ax, ay, bx, by;
    pts_t   pts_in;

    logic signed [DIFF_W-1:0]  ex_reg, ey_reg, upx_reg, upy_reg, uqx_reg, uqy_reg;
    logic signed [PROD_W-1:0]  p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [CROSS_W-1:0] d1_reg, d2_reg, d1b_reg, d2b_reg;
    logic signed [DEN_W-1:0]   den_reg;
    pts_t                      pts1_reg, pts2_reg, pts3_reg, pts4_reg;
    cross_item_t               item_reg, item_next;
    logic [DEN_W-1:0]          den_mag;

    assign adv            = !vld_reg[4] || item_ready;
    assign items_in.ready = adv;
    assign item_valid     = vld_reg[4];
    assign item           = item_reg;

    assign ax = to_coord(items_in.line1_start_x);
    assign ay = to_coord(items_in.line1_start_y);
    assign bx = to_coord(items_in.line1_end_x);
    assign by = to_coord(items_in.line1_end_y);
    assign pts_in.px = to_coord(items_in.line2_start_x);
    assign pts_in.py = to_coord(items_in.line2_start_y);
    assign pts_in.qx = to_coord(items_in.line2_end_x);
    assign pts_in.qy = to_coord(items_in.line2_end_y);

    always_comb
    begin
        den_mag = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
        item_next.parallel = (den_reg == '0) || (CMP_W'(den_mag) < CMP_W'(tol));
        item_next.d1  = d1b_reg;
        item_next.d2  = d2b_reg;
        item_next.den = den_reg;
        item_next.pts = pts4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], items_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg   <= DIFF_W'(bx) - DIFF_W'(ax);
            ey_reg   <= DIFF_W'(by) - DIFF_W'(ay);
            upx_reg  <= DIFF_W'(pts_in.px) - DIFF_W'(ax);
            upy_reg  <= DIFF_W'(pts_in.py) - DIFF_W'(ay);
            uqx_reg  <= DIFF_W'(pts_in.qx) - DIFF_W'(ax);
            uqy_reg  <= DIFF_W'(pts_in.qy) - DIFF_W'(ay);
            pts1_reg <= pts_in;

            p1_reg   <= upx_reg * ey_reg;
            p2_reg   <= upy_reg * ex_reg;
            p3_reg   <= uqx_reg * ey_reg;
            p4_reg   <= uqy_reg * ex_reg;
            pts2_reg <= pts1_reg;

            d1_reg   <= CROSS_W'(p1_reg) - CROSS_W'(p2_reg);
            d2_reg   <= CROSS_W'(p3_reg) - CROSS_W'(p4_reg);
            pts3_reg <= pts2_reg;

            den_reg  <= DEN_W'(d1_reg) - DEN_W'(d2_reg);
            d1b_reg  <= d1_reg;
            d2b_reg  <= d2_reg;
            pts4_reg <= pts3_reg;

            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### design/lli_fifo.sv
// Short queue between the front end and the divider back end.
// Depends on lli_pkg and the assertion macro header.
`default_nettype none

module lli_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lli_pkg::cross_item_t push_data,
    output logic                      full,
    input  wire logic                 pop,
    output lli_pkg::cross_item_t      pop_data,
    output logic                      empty
);
    import lli_pkg::*;

    cross_item_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "line_line_intersection_assert.svh"

    `LLI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH))
    `LLI_ASSERT_NXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `LLI_ASSERT_NXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1)
    `LLI_ASSERT_IMP(a_ptr_gap, 1'b1,
                    FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])

endmodule

`default_nettype wire

### design/lli_back.sv
// Back end: numerators by split multiplies, a bit-per-stage restoring divider
// and saturation into the output register. Depends on lli_pkg and lli_out_if.
`default_nettype none

module lli_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lli_pkg::cross_item_t item,
    input  wire logic                 item_valid,
    output logic                      item_pop,
    lli_out_if.source                 results_out
);
    import lli_pkg::*;

    localparam int NSTG = 5 + QUO_W + 1;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             big;
    } div_lane_t;

    typedef struct packed {
        logic             parallel;
        logic [DEN_W-1:0] dmag;
        div_lane_t        x;
        div_lane_t        y;
    } div_stage_t;

    logic            adv;
    logic [NSTG-1:0] vld_reg;

    logic signed [CROSS_W-1:0] mul_d [4];
    coord_t                    mul_c [4];
    logic signed [PLO_W-1:0]   lo_reg [4];
    logic signed [PHI_W-1:0]   hi_reg [4];
    logic signed [TERM_W-1:0]  term_reg [4];
    logic signed [NUM_W-1:0]   num_reg [2];
    logic [NUM_W-1:0]          mag_reg [2];
    logic [1:0]                neg_reg;
    logic signed [DEN_W-1:0]   den1_reg;
    logic [DEN_W-1:0]          dmag2_reg, dmag3_reg, dmag4_reg;
    logic                      dneg2_reg, dneg3_reg;
    logic                      par1_reg, par2_reg, par3_reg, par4_reg;
    div_stage_t                div_reg  [QUO_W+1];
    div_stage_t                div_next [QUO_W+1];

    logic [COORD_WIDTH:0]      sat_x, sat_y;
    logic [FIELD_W-1:0]        meet_x_reg, meet_y_reg;
    logic                      meet_reg, ovf_reg;

    function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] d);
        logic [DEN_W:0] sh;
        logic           ge;
        div_lane_t      r;
        sh     = {l.rem, l.low[QUO_W-1]};
        ge     = (sh >= {1'b0, d});
        r      = l;
        r.rem  = ge ? DEN_W'(sh - {1'b0, d}) : DEN_W'(sh);
        r.low  = l.low << 1;
        r.quo  = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    function automatic div_lane_t div_init(input logic [NUM_W-1:0] m, input logic n,
                                           input logic [DEN_W-1:0] d);
        div_lane_t r;
        r.big = ({1'b0, m} >= ((NUM_W+1)'(d) << QUO_W));
        r.rem = DEN_W'(m >> QUO_W);
        r.low = m[QUO_W-1:0];
        r.quo = '0;
        r.neg = n;
        return r;
    endfunction

    // {overflow, value}
    function automatic logic [COORD_WIDTH:0] saturate(input div_lane_t l);
        logic                   ovf;
        logic [COORD_WIDTH-1:0] v;
        ovf = 1'b0;
        if (l.neg)
        begin
            if (l.big || l.quo > SAT_LIM)
            begin
                ovf = 1'b1;
                v   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end
            else
            begin
                v = COORD_WIDTH'(QUO_W'(0) - l.quo);
            end
        end
        else
        begin
            if (l.big || l.quo > SAT_LIM - 1'b1)
            begin
                ovf = 1'b1;
                v   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
            else
            begin
                v = l.quo[COORD_WIDTH-1:0];
            end
        end
        return {ovf, v};
    endfunction

    assign adv      = !vld_reg[NSTG-1] || results_out.ready;
    assign item_pop = adv && item_valid;

    assign results_out.valid          = vld_reg[NSTG-1];
    assign results_out.meet_x         = meet_x_reg;
    assign results_out.meet_y         = meet_y_reg;
    assign results_out.lines_meet     = meet_reg;
    assign results_out.range_overflow = ovf_reg;

    always_comb
    begin
        mul_d[0] = item.d1;  mul_c[0] = item.pts.qx;
        mul_d[1] = item.d2;  mul_c[1] = item.pts.px;
        mul_d[2] = item.d1;  mul_c[2] = item.pts.qy;
        mul_d[3] = item.d2;  mul_c[3] = item.pts.py;
    end

    always_comb
    begin
        div_next[0].parallel = par4_reg;
        div_next[0].dmag     = dmag4_reg;
        div_next[0].x        = div_init(mag_reg[0], neg_reg[0], dmag4_reg);
        div_next[0].y        = div_init(mag_reg[1], neg_reg[1], dmag4_reg);
        for (int k = 0; k < QUO_W; k++)
        begin
            div_next[k+1]   = div_reg[k];
            div_next[k+1].x = div_step(div_reg[k].x, div_reg[k].dmag);
            div_next[k+1].y = div_step(div_reg[k].y, div_reg[k].dmag);
        end
        sat_x = saturate(div_reg[QUO_W].x);
        sat_y = saturate(div_reg[QUO_W].y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // split d by halves so no multiply exceeds about 35 by 32 bits
            for (int i = 0; i < 4; i++)
            begin
                lo_reg[i] <= $signed({1'b0, mul_d[i][LO_W-1:0]}) * mul_c[i];
                hi_reg[i] <= $signed(mul_d[i][CROSS_W-1:LO_W]) * mul_c[i];
            end
            den1_reg <= item.den;
            par1_reg <= item.parallel;

            for (int i = 0; i < 4; i++)
            begin
                term_reg[i] <= (TERM_W'(hi_reg[i]) <<< LO_W) + TERM_W'(lo_reg[i]);
            end
            dmag2_reg <= den1_reg[DEN_W-1] ? DEN_W'(-den1_reg) : DEN_W'(den1_reg);
            dneg2_reg <= den1_reg[DEN_W-1];
            par2_reg  <= par1_reg;

            num_reg[0] <= NUM_W'(term_reg[0]) - NUM_W'(term_reg[1]);
            num_reg[1] <= NUM_W'(term_reg[2]) - NUM_W'(term_reg[3]);
            dmag3_reg  <= dmag2_reg;
            dneg3_reg  <= dneg2_reg;
            par3_reg   <= par2_reg;

            for (int i = 0; i < 2; i++)
            begin
                mag_reg[i] <= num_reg[i][NUM_W-1] ? NUM_W'(-num_reg[i]) : NUM_W'(num_reg[i]);
                neg_reg[i] <= num_reg[i][NUM_W-1] ^ dneg3_reg;
            end
            dmag4_reg <= dmag3_reg;
            par4_reg  <= par3_reg;

            for (int k = 0; k <= QUO_W; k++)
            begin
                div_reg[k] <= div_next[k];
            end

            if (div_reg[QUO_W].parallel)
            begin
                meet_x_reg <= '0;
                meet_y_reg <= '0;
                meet_reg   <= 1'b0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                meet_x_reg <= to_field(coord_t'(sat_x[COORD_WIDTH-1:0]));
                meet_y_reg <= to_field(coord_t'(sat_y[COORD_WIDTH-1:0]));
                meet_reg   <= 1'b1;
                ovf_reg    <= sat_x[COORD_WIDTH] | sat_y[COORD_WIDTH];
            end
        end
    end

endmodule

`default_nettype wire

### design/line_line_intersection.sv
// Top level of the two-line intersection block and its tolerance register.
// Depends on lli_pkg, lli_if, lli_front, lli_fifo and lli_back.
`default_nettype none

// Intersection of line AB with line PQ in signed Q16.16, one point set per
// clock sustained while results_out is ready. An item passes a five-stage
// front end (differences, cross products, parallel test against
// parallel_tolerance), a four-entry queue, and a back end of four stages of
// split multiplies and wide adds, a restoring divider that resolves one
// quotient bit per stage over 33 stages, and the output register. The
// divider pipeline sets the latency. parallel_tolerance resets to 1 and is
// written with cfg_we; write it only while the block is idle.
module line_line_intersection (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [lli_pkg::TOL_W-1:0] cfg_wdata,
    lli_in_if.sink                         items_in,
    lli_out_if.source                      results_out
);
    import lli_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    cross_item_t      front_item, queue_item;
    logic             front_valid, queue_full, queue_empty, queue_pop, queue_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_W'(1);
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    assign queue_push = front_valid && !queue_full;

    lli_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items_in   (items_in),
        .tol        (tol_reg),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (!queue_full)
    );

    lli_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_data  (queue_item),
        .empty     (queue_empty)
    );

    lli_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (queue_item),
        .item_valid  (!queue_empty),
        .item_pop    (queue_pop),
        .results_out (results_out)
    );

endmodule

`default_nettype wire
